FILE: hdl/gdg_pkg.sv
package gdg_pkg;

  // Long division: two quotient bits per pipeline stage, 32 bits in all
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = 32 / DIV_STEPS;

  // exp(-f) series length and the most exp(-1) products that leave a nonzero value
  localparam int unsigned EXP_TERMS = 12;
  localparam int unsigned EXP_MULS  = 23;

  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0] COEF_Q32  = 32'd1713442843;
  localparam logic [31:0] INVSQ_Q32 = 32'd1713444047;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // Reciprocals ceil(2^36/n) for the odd-factor series divisors
  localparam int unsigned RECIP_SHIFT = 36;
  typedef logic [34:0] recip_t;
  localparam recip_t RECIP [13] = '{
    35'd0, 35'd0, 35'd0,
    35'(((64'd1 << 36) + 64'd2) / 64'd3),
    35'd0,
    35'(((64'd1 << 36) + 64'd4) / 64'd5),
    35'(((64'd1 << 36) + 64'd5) / 64'd6),
    35'(((64'd1 << 36) + 64'd6) / 64'd7),
    35'd0,
    35'(((64'd1 << 36) + 64'd8) / 64'd9),
    35'(((64'd1 << 36) + 64'd9) / 64'd10),
    35'(((64'd1 << 36) + 64'd10) / 64'd11),
    35'(((64'd1 << 36) + 64'd11) / 64'd12)
  };

  // One division step state
  typedef struct packed {
    logic [61:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } div_t;

  // Front-end result: signs, magnitudes, ratio and half square
  typedef struct packed {
    logic        dneg;
    logic        gneg;
    logic        zero;
    logic        big;
    logic [31:0] ag;
    logic [30:0] s;
    logic [31:0] r28;
    logic [38:0] h;
  } front_t;

  typedef struct packed {
    front_t      f;
    logic [32:0] e;
  } efront_t;

  typedef struct packed {
    logic [30:0] density;
    logic [31:0] center_grad_term;
    logic [31:0] width_grad_term;
    logic [1:0]  status;
  } res_t;

  // floor(v / n) for a series divisor n in 1..12
  function automatic logic [31:0] horner_div(input logic [31:0] v, input logic [3:0] n);
    logic [66:0] p;
    p = 67'(v) * 67'(RECIP[n]);
    case (n)
      4'd1:    return v;
      4'd2:    return v >> 1;
      4'd4:    return v >> 2;
      4'd8:    return v >> 3;
      default: return 32'(p[66:RECIP_SHIFT]);
    endcase
  endfunction

  // Restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic div_t div_step(input div_t x, input logic [61:0] dv);
    div_t        y;
    logic [62:0] t;
    logic        fit;
    t     = {x.rem, x.low[31]};
    fit   = t >= {1'b0, dv};
    y.low = {x.low[30:0], 1'b0};
    y.q   = {x.q[30:0], fit};
    y.rem = fit ? 62'(t - {1'b0, dv}) : t[61:0];
    return y;
  endfunction

  // exp(-1) in Q0.32 as the truncated square of the series value at one half
  function automatic logic [31:0] calc_e1();
    logic [32:0] acc;
    logic [63:0] sq;
    acc = ONE_Q32;
    for (int t = 0; t < EXP_TERMS; t++) begin
      acc = ONE_Q32 - 33'(horner_div(acc[32:1], 4'(EXP_TERMS - t)));
    end
    sq = 64'(acc[31:0]) * 64'(acc[31:0]);
    return sq[63:32];
  endfunction

  localparam logic [31:0] E1_Q32 = calc_e1();

endpackage

FILE: hdl/gdg_if.sv
interface gdg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] center;
  logic        [30:0] width;
  logic signed [31:0] upstream_grad;

  modport source (output valid, output position, output center, output width,
                  output upstream_grad, input ready);
  modport sink (input valid, input position, input center, input width,
                input upstream_grad, output ready);
endinterface

interface gdg_out_if;
  logic               valid;
  logic               ready;
  logic        [30:0] density;
  logic signed [31:0] center_grad_term;
  logic signed [31:0] width_grad_term;
  logic        [1:0]  status;

  modport source (output valid, output density, output center_grad_term,
                  output width_grad_term, output status, input ready);
  modport sink (input valid, input density, input center_grad_term,
                input width_grad_term, input status, output ready);
endinterface

FILE: hdl/gdg_ratio.sv
module gdg_ratio import gdg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] position,
  input  logic signed [31:0] center,
  input  logic        [30:0] width,
  input  logic signed [31:0] upstream_grad,
  output logic               out_valid,
  output front_t             out_item
);

  typedef struct packed {
    logic        dneg;
    logic        gneg;
    logic        zero;
    logic        big;
    logic [31:0] ag;
    logic [30:0] s;
    div_t        dv;
  } rat_t;

  rat_t              st_r   [DIV_STAGES+1];
  rat_t              st_nxt [DIV_STAGES+1];
  logic [DIV_STAGES:0] vld_r;
  front_t            front_r;
  front_t            front_nxt;
  logic              front_vld_r;

  logic [32:0] d;
  logic [32:0] ad;
  logic [63:0] sq;

  // Take |p - c| and |g|, flag zero width and ratios of 16 or more
  always_comb begin
    d                 = {position[31], position} - {center[31], center};
    ad                = d[32] ? (33'd0 - d) : d;
    st_nxt[0].dneg    = d[32];
    st_nxt[0].gneg    = upstream_grad[31];
    st_nxt[0].ag      = upstream_grad[31] ? (32'd0 - upstream_grad) : upstream_grad;
    st_nxt[0].s       = width;
    st_nxt[0].zero    = width == '0;
    st_nxt[0].big     = {2'b0, ad} >= {width, 4'b0};
    st_nxt[0].dv.rem  = 62'(ad[32:4]);
    st_nxt[0].dv.low  = {ad[3:0], 28'd0};
    st_nxt[0].dv.q    = '0;
    // Advance the ratio division, two bits per stage
    for (int k = 1; k <= DIV_STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        st_nxt[k].dv = div_step(st_nxt[k].dv, 62'(st_r[k-1].s));
      end
    end
    // Square the ratio into h = r^2 / 2
    sq                  = 64'(st_r[DIV_STAGES].dv.q) * 64'(st_r[DIV_STAGES].dv.q);
    front_nxt.dneg      = st_r[DIV_STAGES].dneg;
    front_nxt.gneg      = st_r[DIV_STAGES].gneg;
    front_nxt.zero      = st_r[DIV_STAGES].zero;
    front_nxt.big       = st_r[DIV_STAGES].big;
    front_nxt.ag        = st_r[DIV_STAGES].ag;
    front_nxt.s         = st_r[DIV_STAGES].s;
    front_nxt.r28       = st_r[DIV_STAGES].dv.q;
    front_nxt.h         = sq[63:25];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      front_vld_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DIV_STAGES-1:0], in_valid};
      front_vld_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r    <= st_nxt;
      front_r <= front_nxt;
    end
  end

  assign out_valid = front_vld_r;
  assign out_item  = front_r;

endmodule

FILE: hdl/gdg_exp.sv
module gdg_exp import gdg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  front_t  in_item,
  output logic    out_valid,
  output efront_t out_item
);

  localparam int unsigned HORNER_STAGES = 2 * EXP_TERMS;
  localparam int unsigned LAST          = HORNER_STAGES + EXP_MULS;

  typedef struct packed {
    front_t      f;
    logic [32:0] acc;
    logic [31:0] v;
  } xp_t;

  xp_t         x_r   [LAST+1];
  xp_t         x_nxt [LAST+1];
  logic [LAST:0] vld_r;
  logic [64:0] prod;

  always_comb begin
    prod         = '0;
    x_nxt[0].f   = in_item;
    x_nxt[0].acc = ONE_Q32;
    x_nxt[0].v   = '0;
    // Series for exp(-frac): multiply stage, then divide-and-subtract stage
    for (int t = 0; t < EXP_TERMS; t++) begin
      x_nxt[2*t+1]   = x_r[2*t];
      prod           = 65'(x_r[2*t].f.h[31:0]) * 65'(x_r[2*t].acc);
      x_nxt[2*t+1].v = prod[63:32];
      x_nxt[2*t+2]     = x_r[2*t+1];
      x_nxt[2*t+2].acc = ONE_Q32 - 33'(horner_div(x_r[2*t+1].v, 4'(EXP_TERMS - t)));
    end
    // One exp(-1) product per stage while the integer part calls for it
    for (int k = 0; k < EXP_MULS; k++) begin
      x_nxt[HORNER_STAGES+k+1] = x_r[HORNER_STAGES+k];
      prod = 65'(x_r[HORNER_STAGES+k].acc) * 65'(E1_Q32);
      if (7'(k) < x_r[HORNER_STAGES+k].f.h[38:32]) begin
        x_nxt[HORNER_STAGES+k+1].acc = prod[64:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
    end
  end

  assign out_valid  = vld_r[LAST];
  assign out_item.f = x_r[LAST].f;
  assign out_item.e = x_r[LAST].acc;

endmodule

FILE: hdl/gdg_terms.sv
module gdg_terms import gdg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  efront_t in_item,
  output logic    out_valid,
  output res_t    out_item
);

  localparam int unsigned PRE_STAGES = 6;
  localparam int unsigned NSTG       = PRE_STAGES + DIV_STAGES;

  typedef struct packed {
    front_t      f;
    logic [30:0] ke;
    logic [30:0] m;
    logic [61:0] s2;
    logic [34:0] cm;
    logic [62:0] mh_lo;
    logic [37:0] mh_hi;
    logic [38:0] y;
    logic        wneg;
    logic [38:0] wmag;
    logic [63:0] p1_lo;
    logic [34:0] p1_hi;
    logic [63:0] p2_lo;
    logic [38:0] p2_hi;
    logic        ov1;
    logic        ov2;
    div_t        d0;
    div_t        d1;
    div_t        d2;
  } trm_t;

  trm_t          tr_r   [NSTG];
  trm_t          tr_nxt [NSTG];
  logic [NSTG:0] vld_r;
  res_t          out_r;
  res_t          out_nxt;

  logic [64:0] p_ke;
  logic [64:0] p_m;
  logic [62:0] p_cm;
  logic [69:0] mh;
  logic [38:0] ke39;
  logic [66:0] n1;
  logic [70:0] n2;
  logic [31:0] cap1;
  logic [31:0] cap2;
  logic [31:0] mag1;
  logic [31:0] mag2;
  logic        sat1;
  logic        sat2;
  logic        neg1;
  logic        neg2;
  trm_t        lt;

  always_comb begin
    // Scale the exponential by both constants, square the width
    tr_nxt[0]      = '0;
    tr_nxt[0].f    = in_item.f;
    p_ke           = 65'(INVSQ_Q32) * 65'(in_item.e);
    p_m            = 65'(COEF_Q32) * 65'(in_item.e);
    tr_nxt[0].ke   = p_ke[62:32];
    tr_nxt[0].m    = p_m[62:32];
    tr_nxt[0].s2   = 62'(in_item.f.s) * 62'(in_item.f.s);

    // Center magnitude and the two halves of m * h
    tr_nxt[1]       = tr_r[0];
    p_cm            = 63'(tr_r[0].m) * 63'(tr_r[0].f.r28);
    tr_nxt[1].cm    = p_cm[62:28];
    tr_nxt[1].mh_lo = 63'(tr_r[0].m) * 63'(tr_r[0].f.h[31:0]);
    tr_nxt[1].mh_hi = 38'(tr_r[0].m) * 38'(tr_r[0].f.h[38:32]);

    // Join the halves into y = m * h / 2^31
    tr_nxt[2]   = tr_r[1];
    mh          = 70'(tr_r[1].mh_lo) + {tr_r[1].mh_hi, 32'd0};
    tr_nxt[2].y = mh[69:31];

    // Width magnitude |y - ke| and its sign
    tr_nxt[3]      = tr_r[2];
    ke39           = {8'd0, tr_r[2].ke};
    tr_nxt[3].wneg = tr_r[2].y < ke39;
    tr_nxt[3].wmag = (tr_r[2].y < ke39) ? (ke39 - tr_r[2].y) : (tr_r[2].y - ke39);

    // Gradient products in partial products
    tr_nxt[4]       = tr_r[3];
    tr_nxt[4].p1_lo = 64'(tr_r[3].f.ag) * 64'(tr_r[3].cm[31:0]);
    tr_nxt[4].p1_hi = 35'(tr_r[3].f.ag) * 35'(tr_r[3].cm[34:32]);
    tr_nxt[4].p2_lo = 64'(tr_r[3].f.ag) * 64'(tr_r[3].wmag[31:0]);
    tr_nxt[4].p2_hi = 39'(tr_r[3].f.ag) * 39'(tr_r[3].wmag[38:32]);

    // Sum the products, flag quotients of 2^32 or more, load the dividers
    tr_nxt[5]        = tr_r[4];
    n1               = 67'(tr_r[4].p1_lo) + {tr_r[4].p1_hi, 32'd0};
    n2               = 71'(tr_r[4].p2_lo) + {tr_r[4].p2_hi, 32'd0};
    tr_nxt[5].ov1    = {27'd0, n1[66:32]} >= tr_r[4].s2;
    tr_nxt[5].ov2    = {23'd0, n2[70:32]} >= tr_r[4].s2;
    tr_nxt[5].d0.rem = '0;
    tr_nxt[5].d0.low = {1'b0, tr_r[4].ke};
    tr_nxt[5].d0.q   = '0;
    tr_nxt[5].d1.rem = 62'(n1[66:32]);
    tr_nxt[5].d1.low = n1[31:0];
    tr_nxt[5].d1.q   = '0;
    tr_nxt[5].d2.rem = 62'(n2[70:32]);
    tr_nxt[5].d2.low = n2[31:0];
    tr_nxt[5].d2.q   = '0;

    // Advance the three dividers together
    for (int k = PRE_STAGES; k < NSTG; k++) begin
      tr_nxt[k] = tr_r[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        tr_nxt[k].d0 = div_step(tr_nxt[k].d0, 62'(tr_r[k-1].f.s));
        tr_nxt[k].d1 = div_step(tr_nxt[k].d1, tr_r[k-1].s2);
        tr_nxt[k].d2 = div_step(tr_nxt[k].d2, tr_r[k-1].s2);
      end
    end

    // Clamp, apply signs, pick the status
    lt   = tr_r[NSTG-1];
    neg1 = lt.f.dneg ^ lt.f.gneg;
    neg2 = lt.wneg ^ lt.f.gneg;
    cap1 = neg1 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    cap2 = neg2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat1 = lt.ov1 || (lt.d1.q > cap1);
    sat2 = lt.ov2 || (lt.d2.q > cap2);
    mag1 = sat1 ? cap1 : lt.d1.q;
    mag2 = sat2 ? cap2 : lt.d2.q;
    if (lt.f.zero) begin
      out_nxt = '{density: '0, center_grad_term: '0, width_grad_term: '0, status: STAT_ZERO};
    end else if (lt.f.big) begin
      out_nxt = '{density: '0, center_grad_term: '0, width_grad_term: '0, status: STAT_OK};
    end else begin
      out_nxt.density          = lt.d0.q[30:0];
      out_nxt.center_grad_term = neg1 ? (32'd0 - mag1) : mag1;
      out_nxt.width_grad_term  = neg2 ? (32'd0 - mag2) : mag2;
      out_nxt.status           = (sat1 || sat2) ? STAT_SAT : STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr_r  <= tr_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[NSTG];
  assign out_item  = out_r;

endmodule

FILE: hdl/gaussian_density_and_gradients.sv
// channel  | dir | handshake         | payload
// in_ch    | in  | valid/ready       | position, center, width, upstream_grad
// out_ch   | out | valid/ready       | density, center_grad_term, width_grad_term, status
//
// One item enters per cycle while out_ch is not stalled; each result passes in order
// through the ratio divider, the exp series and exp(-1) products
// and the product and gradient dividers.
// Reset clears all valid bits; payload registers are not reset.
// A stall on out_ch freezes the whole pipeline; in_ch.ready follows it.
module gaussian_density_and_gradients import gdg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  gdg_in_if.sink           in_ch,
  gdg_out_if.source        out_ch
);

  logic    en;
  logic    front_vld;
  front_t  front_item;
  logic    exp_vld;
  efront_t exp_item;
  logic    res_vld;
  res_t    res_item;

  // Advance when the output register is empty or being taken
  assign en          = !res_vld || out_ch.ready;
  assign in_ch.ready = en;

  gdg_ratio u_ratio (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_ch.valid),
    .position      (in_ch.position),
    .center        (in_ch.center),
    .width         (in_ch.width),
    .upstream_grad (in_ch.upstream_grad),
    .out_valid     (front_vld),
    .out_item      (front_item)
  );

  gdg_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_vld),
    .in_item   (front_item),
    .out_valid (exp_vld),
    .out_item  (exp_item)
  );

  gdg_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (exp_vld),
    .in_item   (exp_item),
    .out_valid (res_vld),
    .out_item  (res_item)
  );

  assign out_ch.valid            = res_vld;
  assign out_ch.density          = res_item.density;
  assign out_ch.center_grad_term = res_item.center_grad_term;
  assign out_ch.width_grad_term  = res_item.width_grad_term;
  assign out_ch.status           = res_item.status;

endmodule
